// File: hw/rtl/urlq_pkg.sv
// Shared types and constants for the UART receive line queue.
package urlq_pkg;

  typedef logic [7:0] byte_t;

  // Width of the caller buffer size field.
  localparam int SIZE_W = 7;

  // Operation codes carried by the op field.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TAKE = 1'b1;

  // Line terminators.
  localparam byte_t CH_LF = 8'h0A;
  localparam byte_t CH_CR = 8'h0D;

endpackage

// File: hw/rtl/urlq_ram.sv
// Simple dual-port synchronous RAM with registered read.
module urlq_ram import urlq_pkg::*; #(
  parameter int AW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  byte_t         wdata,
  input  logic [AW-1:0] raddr,
  output byte_t         rdata
);

  byte_t mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/uart_rx_line_queue_unit.sv
// Received bytes are accepted while idle with no copy write pending and the output free;
// a finished line with stored characters then blocks input while it is copied from the
// partial-line RAM to the line RAM. A take is answered from a register when rejected or the
// queue is empty, after the length RAM read when it returns no character, else each character
// follows a registered line RAM read, can be held by output back-pressure, and input waits.
// Reset clears the queue pointers, line count and partial length; the RAMs are not cleared.
module uart_rx_line_queue_unit import urlq_pkg::*; #(
  parameter int LINE_BYTES  = 64,
  parameter int QUEUE_LINES = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  byte_t             data_byte,
  input  logic [SIZE_W-1:0] out_size,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              found,
  output logic              has_char,
  output byte_t             ch,
  output logic              last,
  output logic              more_pending
);

  localparam int POS_W   = $clog2(LINE_BYTES);
  localparam int SLOT_W  = (QUEUE_LINES > 1) ? $clog2(QUEUE_LINES) : 1;
  localparam int CNT_W   = $clog2(QUEUE_LINES + 1);
  localparam int PART_AW = (LINE_BYTES - 1 > 1) ? $clog2(LINE_BYTES - 1) : 1;
  localparam int STORE_AW = SLOT_W + POS_W;
  localparam logic [POS_W-1:0]  MAX_LEN   = POS_W'(LINE_BYTES - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_LINES - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_LINES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COPY,
    ST_TAKE_LEN,
    ST_STREAM
  } state_t;

  state_t state;

  logic [POS_W-1:0]  plen;
  logic [POS_W-1:0]  zlen;
  logic              zseen;
  logic [SLOT_W-1:0] head_slot;
  logic [SLOT_W-1:0] tail_slot;
  logic [CNT_W-1:0]  line_count;

  logic [POS_W-1:0]  cp_idx;
  logic [POS_W-1:0]  cp_n;
  logic [SLOT_W-1:0] cp_slot;
  logic              cp_pend;
  logic [POS_W-1:0]  cp_wr_idx;

  logic [SLOT_W-1:0] tk_slot;
  logic [SIZE_W-1:0] tk_lim;
  logic [POS_W-1:0]  tk_n;
  logic [POS_W-1:0]  tk_idx;
  logic              tk_more;
  logic              rd_ok;

  byte_t part_rdata;
  byte_t store_rdata;
  byte_t len_rdata;

  logic              accept;
  logic              is_term;
  logic [POS_W-1:0]  line_n;
  logic              push;
  logic              part_we;
  logic [POS_W-1:0]  stored_len;
  logic [POS_W-1:0]  take_n;
  logic              out_free;
  logic              char_load;
  logic              char_last;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == ST_IDLE) && !cp_pend && out_free;
  assign accept   = in_valid && in_ready;
  assign is_term  = (data_byte == CH_LF) || (data_byte == CH_CR);

  // A zero byte cuts the stored line at its position.
  assign line_n  = zseen ? zlen : plen;
  assign push    = accept && (op == OP_BYTE) && is_term && (plen != '0) &&
                   (line_count < FULL_CNT);
  assign part_we = accept && (op == OP_BYTE) && !is_term && (plen < MAX_LEN);

  assign stored_len = len_rdata[POS_W-1:0];
  assign take_n     = (SIZE_W'(stored_len) > tk_lim) ? tk_lim[POS_W-1:0] : stored_len;

  assign char_load = (state == ST_STREAM) && rd_ok && out_free;
  assign char_last = (tk_idx == tk_n - 1'b1);

  urlq_ram #(.AW(PART_AW)) u_part_ram (
    .clk   (clk),
    .we    (part_we),
    .waddr (plen[PART_AW-1:0]),
    .wdata (data_byte),
    .raddr (cp_idx[PART_AW-1:0]),
    .rdata (part_rdata)
  );

  urlq_ram #(.AW(STORE_AW)) u_line_ram (
    .clk   (clk),
    .we    (cp_pend),
    .waddr ({cp_slot, cp_wr_idx}),
    .wdata (part_rdata),
    .raddr ({tk_slot, tk_idx}),
    .rdata (store_rdata)
  );

  urlq_ram #(.AW(SLOT_W)) u_len_ram (
    .clk   (clk),
    .we    (push),
    .waddr (head_slot),
    .wdata (8'(line_n)),
    .raddr (tail_slot),
    .rdata (len_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      plen       <= '0;
      zseen      <= 1'b0;
      head_slot  <= '0;
      tail_slot  <= '0;
      line_count <= '0;
      cp_pend    <= 1'b0;
      rd_ok      <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      cp_pend <= 1'b0;
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept && (op == OP_BYTE)) begin
            if (is_term) begin
              if (plen != '0) begin
                plen  <= '0;
                zseen <= 1'b0;
              end
              if (push) begin
                cp_n       <= line_n;
                cp_idx     <= '0;
                cp_slot    <= head_slot;
                head_slot  <= slot_inc(head_slot);
                line_count <= line_count + 1'b1;
                if (line_n != '0) begin
                  state <= ST_COPY;
                end
              end
            end else if (plen < MAX_LEN) begin
              plen <= plen + 1'b1;
              if (!zseen && (data_byte == 8'h00)) begin
                zseen <= 1'b1;
                zlen  <= plen;
              end
            end else begin
              // Overlong line: drop it along with this byte.
              plen  <= '0;
              zseen <= 1'b0;
            end
          end else if (accept) begin
            if ((out_size == '0) || (line_count == '0)) begin
              out_valid    <= 1'b1;
              found        <= 1'b0;
              has_char     <= 1'b0;
              ch           <= '0;
              last         <= 1'b1;
              more_pending <= (out_size == '0) && (line_count != '0);
            end else begin
              tk_slot    <= tail_slot;
              tk_lim     <= out_size - 1'b1;
              tk_more    <= (line_count != CNT_W'(1));
              tail_slot  <= slot_inc(tail_slot);
              line_count <= line_count - 1'b1;
              state      <= ST_TAKE_LEN;
            end
          end
        end
        ST_COPY: begin
          cp_pend   <= 1'b1;
          cp_wr_idx <= cp_idx;
          if (cp_idx == cp_n - 1'b1) begin
            state <= ST_IDLE;
          end else begin
            cp_idx <= cp_idx + 1'b1;
          end
        end
        ST_TAKE_LEN: begin
          if (take_n == '0) begin
            out_valid    <= 1'b1;
            found        <= 1'b1;
            has_char     <= 1'b0;
            ch           <= '0;
            last         <= 1'b1;
            more_pending <= tk_more;
            state        <= ST_IDLE;
          end else begin
            tk_n   <= take_n;
            tk_idx <= '0;
            rd_ok  <= 1'b0;
            state  <= ST_STREAM;
          end
        end
        ST_STREAM: begin
          // The line RAM read is registered, so rd_ok is cleared on each address change.
          rd_ok <= 1'b1;
          if (char_load) begin
            out_valid    <= 1'b1;
            found        <= 1'b1;
            has_char     <= 1'b1;
            ch           <= store_rdata;
            last         <= char_last;
            more_pending <= tk_more;
            if (char_last) begin
              state <= ST_IDLE;
            end else begin
              tk_idx <= tk_idx + 1'b1;
              rd_ok  <= 1'b0;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    line_count <= FULL_CNT)
    else $error("line count exceeds queue depth");

  a_ptr_empty: assert property (@(posedge clk) disable iff (rst)
    (line_count == '0) |-> (head_slot == tail_slot))
    else $error("empty queue with head and tail apart");

  a_ptr_full: assert property (@(posedge clk) disable iff (rst)
    (line_count == FULL_CNT) |-> (head_slot == tail_slot))
    else $error("full queue with head and tail apart");

  a_copy_block: assert property (@(posedge clk) disable iff (rst)
    cp_pend |-> !in_ready)
    else $error("item accepted while a line copy write is pending");

  a_plen_bound: assert property (@(posedge clk) disable iff (rst)
    plen <= MAX_LEN)
    else $error("partial line length out of range");

endmodule
